>>> rtl/core/efjd_pkg.sv
package efjd_pkg;

    localparam int MACHINES_DEFAULT = 32;

    localparam int TIME_W   = 20;
    localparam int PROC_W   = 10;
    localparam int MODE_W   = 2;
    localparam int INDEX_W  = 5;
    localparam int CFG_W    = 6;
    // Wide enough for any machine index and any machine count up to 256.
    localparam int ADDR_W   = 8;
    localparam int COUNT_W  = 9;

    localparam logic [MODE_W-1:0] MODE_LOAD     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DISPATCH = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR    = 2'd2;

    // Search token handed from cell to cell.
    typedef struct packed {
        logic              valid;
        logic              found;
        logic [TIME_W-1:0] finish;
        logic [ADDR_W-1:0] idx;
    } token_t;

    // Broadcast controls from the sequencer to every cell.
    typedef struct packed {
        logic              load;
        logic              clear;
        logic              commit;
        logic [ADDR_W-1:0] addr;
        logic [PROC_W-1:0] proc;
        logic [TIME_W-1:0] finish;
    } ctl_t;

endpackage

>>> rtl/core/efjd_cell.sv
module efjd_cell #(
    parameter int INDEX = 0
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  efjd_pkg::ctl_t                ctl,
    input  logic [efjd_pkg::COUNT_W-1:0]  count,
    input  efjd_pkg::token_t              tok_in,
    output efjd_pkg::token_t              tok_out
);

    logic [efjd_pkg::PROC_W-1:0] proc_reg;
    logic [efjd_pkg::TIME_W-1:0] free_reg;
    logic [efjd_pkg::TIME_W-1:0] free_next;
    efjd_pkg::token_t            tok_reg;
    efjd_pkg::token_t            tok_next;
    logic [efjd_pkg::TIME_W:0]   sum;
    logic [efjd_pkg::TIME_W-1:0] finish;
    logic                        enabled;
    logic                        selected;
    logic                        take;

    assign selected = (ctl.addr == efjd_pkg::ADDR_W'(INDEX));
    assign enabled  = (efjd_pkg::COUNT_W'(INDEX) < count);

    // Finish time on this machine, saturated at the top of the time range.
    assign sum    = {1'b0, free_reg} + (efjd_pkg::TIME_W + 1)'(proc_reg);
    assign finish = sum[efjd_pkg::TIME_W] ? '1 : sum[efjd_pkg::TIME_W-1:0];

    // Strictly smaller wins, so the lowest index keeps a tie.
    assign take = tok_in.valid && enabled && (!tok_in.found || (finish < tok_in.finish));

    always_comb
    begin
        tok_next = tok_in;
        if (take)
        begin
            tok_next.found  = 1'b1;
            tok_next.finish = finish;
            tok_next.idx    = efjd_pkg::ADDR_W'(INDEX);
        end
    end

    always_comb
    begin
        free_next = free_reg;
        if (ctl.clear)
        begin
            free_next = '0;
        end
        else if (ctl.commit && selected)
        begin
            free_next = ctl.finish;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg  <= '0;
            free_reg <= '0;
        end
        else
        begin
            tok_reg  <= tok_next;
            free_reg <= free_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load && selected)
        begin
            proc_reg <= ctl.proc;
        end
    end

    assign tok_out = tok_reg;

endmodule

>>> rtl/core/earliest_finish_job_dispatcher_unit.sv
// Earliest-finish dispatcher over a row of MACHINES cells (1 to 32), each
// holding one machine's processing time and free time. A load or clear item
// leaves the block idle. A dispatch item sends a search token down the row,
// one cell per cycle, and the block takes no new item until the token has
// left the last cell and its result is in the output register; the winning
// cell's free time and the makespan are updated as the token leaves the last
// cell. A finished result waits in the output register while the next item
// is taken, or in hold registers while that is full. Configuration transfers
// are always accepted and must only occur while the block is idle.
module earliest_finish_job_dispatcher_unit #(
    parameter int MACHINES = efjd_pkg::MACHINES_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [efjd_pkg::CFG_W-1:0]    cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [efjd_pkg::MODE_W-1:0]   mode,
    input  logic [efjd_pkg::INDEX_W-1:0]  machine_index,
    input  logic [efjd_pkg::PROC_W-1:0]   proc_time,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [efjd_pkg::INDEX_W-1:0]  machine,
    output logic [efjd_pkg::TIME_W-1:0]   finish_time,
    output logic [efjd_pkg::TIME_W-1:0]   makespan
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_HOLD = 3'b100
    } state_t;

    state_t                          state_reg;
    state_t                          state_next;
    logic [efjd_pkg::CFG_W-1:0]      count_reg;
    logic [efjd_pkg::COUNT_W-1:0]    count_ext;
    logic [efjd_pkg::COUNT_W-1:0]    eff_count;
    logic [efjd_pkg::TIME_W-1:0]     latest_reg;
    logic [efjd_pkg::TIME_W-1:0]     latest_next;
    logic [efjd_pkg::TIME_W-1:0]     new_latest;
    logic                            out_valid_reg;
    logic                            out_valid_next;
    logic [efjd_pkg::INDEX_W-1:0]    machine_reg;
    logic [efjd_pkg::INDEX_W-1:0]    machine_next;
    logic [efjd_pkg::TIME_W-1:0]     finish_reg;
    logic [efjd_pkg::TIME_W-1:0]     finish_next;
    logic [efjd_pkg::TIME_W-1:0]     span_reg;
    logic [efjd_pkg::TIME_W-1:0]     span_next;
    logic [efjd_pkg::INDEX_W-1:0]    hold_machine_reg;
    logic [efjd_pkg::INDEX_W-1:0]    hold_machine_next;
    logic [efjd_pkg::TIME_W-1:0]     hold_finish_reg;
    logic [efjd_pkg::TIME_W-1:0]     hold_finish_next;
    logic [efjd_pkg::TIME_W-1:0]     hold_span_reg;
    logic [efjd_pkg::TIME_W-1:0]     hold_span_next;
    logic                            accept;
    logic                            arrive;
    logic                            out_free;
    efjd_pkg::ctl_t                  ctl;
    efjd_pkg::token_t                head;
    efjd_pkg::token_t                chain [0:MACHINES];
    efjd_pkg::token_t                last;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    assign machine     = machine_reg;
    assign finish_time = finish_reg;
    assign makespan    = span_reg;

    // A count of zero enables machine 0 alone; larger counts stop at MACHINES.
    assign count_ext = efjd_pkg::COUNT_W'(count_reg);
    always_comb
    begin
        if (count_reg == '0)
        begin
            eff_count = efjd_pkg::COUNT_W'(1);
        end
        else if (count_ext > efjd_pkg::COUNT_W'(MACHINES))
        begin
            eff_count = efjd_pkg::COUNT_W'(MACHINES);
        end
        else
        begin
            eff_count = count_ext;
        end
    end

    always_comb
    begin
        head       = '0;
        head.valid = accept && (mode == efjd_pkg::MODE_DISPATCH);
    end

    assign chain[0] = head;

    assign last   = chain[MACHINES];
    assign arrive = (state_reg == S_SCAN) && last.valid;

    always_comb
    begin
        ctl.load   = accept && (mode == efjd_pkg::MODE_LOAD);
        ctl.clear  = accept && (mode == efjd_pkg::MODE_CLEAR);
        ctl.commit = arrive;
        ctl.addr   = arrive ? last.idx : efjd_pkg::ADDR_W'(machine_index);
        ctl.proc   = proc_time;
        ctl.finish = last.finish;
    end

    genvar gi;
    generate
        for (gi = 0; gi < MACHINES; gi++)
        begin : g_cell
            efjd_cell #(
                .INDEX (gi)
            ) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .ctl     (ctl),
                .count   (eff_count),
                .tok_in  (chain[gi]),
                .tok_out (chain[gi+1])
            );
        end
    endgenerate

    assign new_latest = (last.finish > latest_reg) ? last.finish : latest_reg;

    always_comb
    begin
        state_next        = state_reg;
        latest_next       = latest_reg;
        out_valid_next    = out_valid_reg;
        machine_next      = machine_reg;
        finish_next       = finish_reg;
        span_next         = span_reg;
        hold_machine_next = hold_machine_reg;
        hold_finish_next  = hold_finish_reg;
        hold_span_next    = hold_span_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (ctl.clear)
        begin
            latest_next = '0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && (mode == efjd_pkg::MODE_DISPATCH))
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (arrive)
                begin
                    latest_next = new_latest;
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        machine_next   = last.idx[efjd_pkg::INDEX_W-1:0];
                        finish_next    = last.finish;
                        span_next      = new_latest;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        hold_machine_next = last.idx[efjd_pkg::INDEX_W-1:0];
                        hold_finish_next  = last.finish;
                        hold_span_next    = new_latest;
                        state_next        = S_HOLD;
                    end
                end
            end
            S_HOLD:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    machine_next   = hold_machine_reg;
                    finish_next    = hold_finish_reg;
                    span_next      = hold_span_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= efjd_pkg::CFG_W'(1);
            latest_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            latest_reg    <= latest_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                count_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        machine_reg      <= machine_next;
        finish_reg       <= finish_next;
        span_reg         <= span_next;
        hold_machine_reg <= hold_machine_next;
        hold_finish_reg  <= hold_finish_next;
        hold_span_reg    <= hold_span_next;
    end

endmodule
